/* rtl/core/tcct_pkg.sv */
package tcct_pkg;

  localparam int unsigned SCREEN_ROWS = 24;
  localparam int unsigned SCREEN_COLS = 80;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [4:0] {
    K_PASS,
    K_HOME,
    K_NL,
    K_EL,
    K_CLR,
    K_CR,
    K_SGR5,
    K_SGR25,
    K_SGR4,
    K_SGR24,
    K_SGR22,
    K_SGR1,
    K_UP,
    K_RIGHT,
    K_LEFT,
    K_DOWN,
    K_ADDR
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] ch;
    logic [6:0] row;
    logic [6:0] col;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } qwr_t;

endpackage

/* rtl/core/tcct_front.sv */
module tcct_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              translate_mode_we_i,
  input  logic              translate_mode_i,
  input  logic              push,
  output logic              full,
  input  logic [6:0]        char_in_i,
  input  logic              q_full_i,
  output tcct_pkg::qwr_t    q_wr_o
);
  import tcct_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COL,
    PH_ROW
  } phase_e;

  localparam logic [6:0] CODE_NOP3  = 7'o003;
  localparam logic [6:0] CODE_NOP4  = 7'o004;
  localparam logic [6:0] CODE_NOP5  = 7'o005;
  localparam logic [6:0] CODE_HOME  = 7'o010;
  localparam logic [6:0] CODE_NL    = 7'o012;
  localparam logic [6:0] CODE_EL    = 7'o013;
  localparam logic [6:0] CODE_CLR   = 7'o014;
  localparam logic [6:0] CODE_CR    = 7'o015;
  localparam logic [6:0] CODE_BLINK = 7'o016;
  localparam logic [6:0] CODE_NOBLK = 7'o017;
  localparam logic [6:0] CODE_ADDR  = 7'o020;
  localparam logic [6:0] CODE_UL    = 7'o024;
  localparam logic [6:0] CODE_NOUL  = 7'o025;
  localparam logic [6:0] CODE_UP    = 7'o027;
  localparam logic [6:0] CODE_RIGHT = 7'o030;
  localparam logic [6:0] CODE_LEFT  = 7'o031;
  localparam logic [6:0] CODE_DOWN  = 7'o032;
  localparam logic [6:0] CODE_DIM   = 7'o034;
  localparam logic [6:0] CODE_BOLD  = 7'o035;
  localparam logic [6:0] CODE_SPEC  = 7'o036;

  localparam logic [7:0] ROWS8 = 8'(SCREEN_ROWS);
  localparam logic [7:0] COLS8 = 8'(SCREEN_COLS);
  localparam logic [6:0] ROWS7 = 7'(SCREEN_ROWS);
  localparam logic [6:0] COLS7 = 7'(SCREEN_COLS);

  logic       mode_q;
  logic       special_q, special_d;
  phase_e     phase_q, phase_d;
  logic [6:0] row_q, row_d;
  logic [6:0] col_q, col_d;
  logic       acc;
  logic       emit;
  kind_e      kind;
  logic [7:0] col_inc;
  logic [7:0] row_inc;

  function automatic logic [6:0] row_down(logic [6:0] r);
    if ({1'b0, r} + 8'd1 > ROWS8) begin
      return 7'd1;
    end
    return r + 7'd1;
  endfunction

  function automatic logic [6:0] row_up(logic [6:0] r);
    if (r <= 7'd1) begin
      return ROWS7;
    end
    return r - 7'd1;
  endfunction

  assign full    = q_full_i;
  assign acc     = push & ~q_full_i;
  assign col_inc = {1'b0, col_q} + 8'd1;
  assign row_inc = {1'b0, row_q} + 8'd1;

  always_comb begin
    special_d = special_q;
    phase_d   = phase_q;
    row_d     = row_q;
    col_d     = col_q;
    emit      = 1'b0;
    kind      = K_PASS;
    if (acc) begin
      if (!mode_q) begin
        emit = 1'b1;
      end else if (special_q) begin
        special_d = 1'b0;
      end else if (phase_q == PH_COL) begin
        col_d   = char_in_i;
        phase_d = PH_ROW;
      end else if (phase_q == PH_ROW) begin
        row_d   = char_in_i;
        phase_d = PH_IDLE;
        emit    = 1'b1;
        kind    = K_ADDR;
      end else begin
        case (char_in_i)
          CODE_NOP3, CODE_NOP4, CODE_NOP5: begin
          end
          CODE_HOME: begin
            emit  = 1'b1;
            kind  = K_HOME;
            row_d = '0;
            col_d = '0;
          end
          CODE_NL: begin
            emit  = 1'b1;
            kind  = K_NL;
            col_d = 7'd1;
            row_d = row_down(row_q);
          end
          CODE_EL: begin
            emit = 1'b1;
            kind = K_EL;
          end
          CODE_CLR: begin
            emit  = 1'b1;
            kind  = K_CLR;
            row_d = '0;
            col_d = '0;
          end
          CODE_CR: begin
            emit  = 1'b1;
            kind  = K_CR;
            col_d = 7'd1;
          end
          CODE_BLINK: begin
            emit = 1'b1;
            kind = K_SGR5;
          end
          CODE_NOBLK: begin
            emit = 1'b1;
            kind = K_SGR25;
          end
          CODE_ADDR: begin
            phase_d = PH_COL;
          end
          CODE_UL: begin
            emit = 1'b1;
            kind = K_SGR4;
          end
          CODE_NOUL: begin
            emit = 1'b1;
            kind = K_SGR24;
          end
          CODE_UP: begin
            emit  = 1'b1;
            kind  = K_UP;
            row_d = row_up(row_q);
          end
          CODE_RIGHT: begin
            emit = 1'b1;
            kind = K_RIGHT;
            if (col_inc > COLS8) begin
              col_d = 7'd1;
              row_d = row_down(row_q);
            end else begin
              col_d = col_inc[6:0];
            end
          end
          CODE_LEFT: begin
            emit = 1'b1;
            kind = K_LEFT;
            if (col_q <= 7'd1) begin
              col_d = COLS7;
              row_d = row_up(row_q);
            end else begin
              col_d = col_q - 7'd1;
            end
          end
          CODE_DOWN: begin
            emit  = 1'b1;
            kind  = K_DOWN;
            row_d = row_down(row_q);
          end
          CODE_DIM: begin
            emit = 1'b1;
            kind = K_SGR22;
          end
          CODE_BOLD: begin
            emit = 1'b1;
            kind = K_SGR1;
          end
          CODE_SPEC: begin
            special_d = 1'b1;
          end
          default: begin
            emit = 1'b1;
            if (col_inc > COLS8) begin
              col_d = 7'd1;
              // data wrap clamps the row instead of wrapping it
              row_d = (row_inc > ROWS8) ? ROWS7 : row_inc[6:0];
            end else begin
              col_d = col_inc[6:0];
            end
          end
        endcase
      end
    end
    q_wr_o.valid    = emit;
    q_wr_o.job.kind = kind;
    q_wr_o.job.ch   = char_in_i;
    q_wr_o.job.row  = row_d;
    q_wr_o.job.col  = col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      special_q <= 1'b0;
      phase_q   <= PH_IDLE;
      row_q     <= '0;
      col_q     <= '0;
    end else begin
      if (translate_mode_we_i) begin
        mode_q <= translate_mode_i;
      end
      special_q <= special_d;
      phase_q   <= phase_d;
      row_q     <= row_d;
      col_q     <= col_d;
    end
  end

endmodule

/* rtl/core/tcct_queue.sv */
module tcct_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcct_pkg::qwr_t  wr_i,
  output logic            full_o,
  output logic            valid_o,
  output tcct_pkg::job_t  head_o,
  input  logic            pop_i
);
  import tcct_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_wr   = wr_i.valid & ~full_o;
  assign do_rd   = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_wr && do_rd) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.job;
    end
  end

endmodule

/* rtl/core/tcct_back.sv */
module tcct_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  tcct_pkg::job_t  q_head_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [6:0]      out_char_o,
  output logic            last_o,
  output logic [6:0]      cursor_row_o,
  output logic [6:0]      cursor_col_o
);
  import tcct_pkg::*;

  localparam logic [6:0] CH_ESC  = 7'h1b;
  localparam logic [6:0] CH_LBR  = 7'h5b;
  localparam logic [6:0] CH_SEMI = 7'h3b;
  localparam logic [6:0] CH_CR   = 7'h0d;
  localparam logic [6:0] CH_LF   = 7'h0a;
  localparam logic [6:0] CH_0    = 7'h30;
  localparam logic [6:0] CH_1    = 7'h31;
  localparam logic [6:0] CH_2    = 7'h32;
  localparam logic [6:0] CH_4    = 7'h34;
  localparam logic [6:0] CH_5    = 7'h35;
  localparam logic [6:0] CH_A    = 7'h41;
  localparam logic [6:0] CH_B    = 7'h42;
  localparam logic [6:0] CH_C    = 7'h43;
  localparam logic [6:0] CH_D    = 7'h44;
  localparam logic [6:0] CH_H    = 7'h48;
  localparam logic [6:0] CH_J    = 7'h4a;
  localparam logic [6:0] CH_K    = 7'h4b;
  localparam logic [6:0] CH_M    = 7'h6d;

  logic        cur_valid_q;
  job_t        cur_q;
  logic [11:0] rbcd_q, cbcd_q;
  logic [1:0]  rn_q, cn_q;
  logic [3:0]  idx_q;
  logic        out_valid_q;
  logic [6:0]  out_char_q;
  logic        out_last_q;
  logic [6:0]  out_row_q, out_col_q;

  logic        adv, fire, is_last, take;
  logic [3:0]  len;
  logic [6:0]  ch;
  logic [11:0] rbcd_n, cbcd_n;

  function automatic logic [11:0] to_bcd(logic [7:0] v);
    logic [11:0] b;
    b = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[3:0] > 4'd4) begin
        b[3:0] = b[3:0] + 4'd3;
      end
      if (b[7:4] > 4'd4) begin
        b[7:4] = b[7:4] + 4'd3;
      end
      b = {b[10:0], v[i]};
    end
    return b;
  endfunction

  function automatic logic [1:0] ndig(logic [11:0] b);
    if (b[11:8] != 4'd0) begin
      return 2'd3;
    end
    if (b[7:4] != 4'd0) begin
      return 2'd2;
    end
    return 2'd1;
  endfunction

  function automatic logic [6:0] dig(logic [11:0] b, logic [1:0] j);
    logic [3:0] d;
    case (j)
      2'd0:    d = b[3:0];
      2'd1:    d = b[7:4];
      default: d = b[11:8];
    endcase
    return CH_0 | {3'b000, d};
  endfunction

  function automatic logic [6:0] tail_char(kind_e k, logic [3:0] t);
    logic [6:0] c;
    c = CH_M;
    case (k)
      K_HOME, K_CLR: begin
        case (t)
          4'd0:    c = CH_1;
          4'd1:    c = CH_SEMI;
          4'd2:    c = CH_1;
          4'd3:    c = CH_H;
          4'd4:    c = CH_ESC;
          4'd5:    c = CH_LBR;
          4'd6:    c = CH_2;
          default: c = CH_J;
        endcase
      end
      K_EL:    c = CH_K;
      K_UP:    c = CH_A;
      K_DOWN:  c = CH_B;
      K_RIGHT: c = CH_C;
      K_LEFT:  c = CH_D;
      K_SGR5:  c = (t == 4'd0) ? CH_5 : CH_M;
      K_SGR4:  c = (t == 4'd0) ? CH_4 : CH_M;
      K_SGR1:  c = (t == 4'd0) ? CH_1 : CH_M;
      K_SGR25: c = (t == 4'd0) ? CH_2 : ((t == 4'd1) ? CH_5 : CH_M);
      K_SGR24: c = (t == 4'd0) ? CH_2 : ((t == 4'd1) ? CH_4 : CH_M);
      K_SGR22: c = (t == 4'd0) ? CH_2 : ((t == 4'd1) ? CH_2 : CH_M);
      default: c = CH_M;
    endcase
    return c;
  endfunction

  always_comb begin
    case (cur_q.kind)
      K_PASS, K_CR:                        len = 4'd1;
      K_NL:                                len = 4'd2;
      K_EL, K_UP, K_DOWN, K_RIGHT, K_LEFT: len = 4'd3;
      K_SGR5, K_SGR4, K_SGR1:              len = 4'd4;
      K_SGR25, K_SGR24, K_SGR22:           len = 4'd5;
      K_HOME:                              len = 4'd6;
      K_CLR:                               len = 4'd10;
      K_ADDR:                              len = {2'b00, rn_q} + {2'b00, cn_q} + 4'd4;
      default:                             len = 4'd1;
    endcase
  end

  // escape sequences: ESC, '[' then a per-kind tail; cursor address is ESC [ r ; c H
  always_comb begin
    logic [3:0] t;
    t = idx_q - 4'd2;
    case (cur_q.kind)
      K_PASS: ch = cur_q.ch;
      K_CR:   ch = CH_CR;
      K_NL:   ch = (idx_q == 4'd0) ? CH_CR : CH_LF;
      default: begin
        if (idx_q == 4'd0) begin
          ch = CH_ESC;
        end else if (idx_q == 4'd1) begin
          ch = CH_LBR;
        end else if (cur_q.kind != K_ADDR) begin
          ch = tail_char(cur_q.kind, t);
        end else if (t < {2'b00, rn_q}) begin
          ch = dig(rbcd_q, 2'({2'b00, rn_q} - 4'd1 - t));
        end else if (t == {2'b00, rn_q}) begin
          ch = CH_SEMI;
        end else if (t < {2'b00, rn_q} + {2'b00, cn_q} + 4'd1) begin
          ch = dig(cbcd_q, 2'({2'b00, rn_q} + {2'b00, cn_q} - t));
        end else begin
          ch = CH_H;
        end
      end
    endcase
  end

  assign adv     = ~out_valid_q | pop;
  assign fire    = cur_valid_q & adv;
  assign is_last = (idx_q == len - 4'd1);
  assign take    = q_valid_i & (~cur_valid_q | (fire & is_last));
  assign q_pop_o = take;
  assign rbcd_n  = to_bcd({1'b0, q_head_i.row} + 8'd1);
  assign cbcd_n  = to_bcd({1'b0, q_head_i.col} + 8'd1);

  assign empty        = ~out_valid_q;
  assign out_char_o   = out_char_q;
  assign last_o       = out_last_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (fire && is_last) begin
        cur_valid_q <= 1'b0;
      end else if (fire) begin
        idx_q <= idx_q + 4'd1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q  <= q_head_i;
      rbcd_q <= rbcd_n;
      cbcd_q <= cbcd_n;
      rn_q   <= ndig(rbcd_n);
      cn_q   <= ndig(cbcd_n);
    end
    if (fire) begin
      out_char_q <= ch;
      out_last_q <= is_last;
      out_row_q  <= cur_q.row;
      out_col_q  <= cur_q.col;
    end
  end

endmodule

/* rtl/core/terminal_control_code_translator_unit.sv */
// An item passes from the job queue through the back end's job register to the output register.
// Throughput: the back end sends one result per cycle while the receiver pops; an item has
//   1 to 10 results, and an item with no result is not queued and costs it none.
// The front end takes one item per cycle while its four-entry job queue has room.
// Reset (rst_ni low, asynchronous): pass-through mode, cursor and parser cleared, queue empty.
module terminal_control_code_translator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       translate_mode_we_i,
  input  logic       translate_mode_i,
  input  logic       push,
  output logic       full,
  input  logic [6:0] char_in_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       last_o,
  output logic [6:0] cursor_row_o,
  output logic [6:0] cursor_col_o
);
  import tcct_pkg::*;

  qwr_t q_wr;
  logic q_full;
  logic q_valid;
  job_t q_head;
  logic q_pop;

  tcct_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .translate_mode_we_i (translate_mode_we_i),
    .translate_mode_i    (translate_mode_i),
    .push                (push),
    .full                (full),
    .char_in_i           (char_in_i),
    .q_full_i            (q_full),
    .q_wr_o              (q_wr)
  );

  tcct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  tcct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char_o),
    .last_o       (last_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

  a_no_wr_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_wr.valid && q_full))
    else $error("job written into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("job taken from empty queue");

  a_item_cursor_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=>
      (!empty && cursor_row_o == $past(cursor_row_o) &&
       cursor_col_o == $past(cursor_col_o)))
    else $error("results of one item not contiguous or cursor changed");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tcct_pkg::*;

  localparam logic [6:0] C_ETX       = 7'o003;
  localparam logic [6:0] C_EOT       = 7'o004;
  localparam logic [6:0] C_ENQ       = 7'o005;
  localparam logic [6:0] C_HOME      = 7'o010;
  localparam logic [6:0] C_NL        = 7'o012;
  localparam logic [6:0] C_EL        = 7'o013;
  localparam logic [6:0] C_CLR       = 7'o014;
  localparam logic [6:0] C_CR        = 7'o015;
  localparam logic [6:0] C_BLINK_ON  = 7'o016;
  localparam logic [6:0] C_BLINK_OFF = 7'o017;
  localparam logic [6:0] C_ADDR      = 7'o020;
  localparam logic [6:0] C_ULINE_ON  = 7'o024;
  localparam logic [6:0] C_ULINE_OFF = 7'o025;
  localparam logic [6:0] C_UP        = 7'o027;
  localparam logic [6:0] C_RIGHT     = 7'o030;
  localparam logic [6:0] C_LEFT      = 7'o031;
  localparam logic [6:0] C_DOWN      = 7'o032;
  localparam logic [6:0] C_NORMAL    = 7'o034;
  localparam logic [6:0] C_BOLD      = 7'o035;
  localparam logic [6:0] C_SPECIAL   = 7'o036;
  localparam logic [6:0] C_DEL       = 7'h7f;
  localparam logic [6:0] C_SPACE     = 7'h20;
  localparam logic [6:0] C_TILDE     = 7'h7e;
  localparam int         N_CTRL      = 18;
  localparam int         DRAIN_CYCLES = 20;

  localparam logic [6:0] CTRL_CODES [N_CTRL] = '{
    C_ETX, C_EOT, C_ENQ, C_HOME, C_NL, C_EL, C_CLR, C_CR, C_BLINK_ON, C_BLINK_OFF,
    C_ULINE_ON, C_ULINE_OFF, C_UP, C_RIGHT, C_LEFT, C_DOWN, C_NORMAL, C_BOLD
  };

  localparam logic [6:0] TRANSLATE_DIRECTED [26] = '{
    C_HOME, C_NL, C_EL, C_CLR, C_CR, C_BLINK_ON, C_BLINK_OFF, C_ULINE_ON, C_ULINE_OFF,
    C_NORMAL, C_BOLD, C_UP, C_RIGHT, C_LEFT, C_DOWN, C_ETX, C_EOT, C_ENQ,
    C_SPECIAL, C_ADDR, C_ADDR, C_DEL, C_DEL, 7'd0, C_DEL, C_RIGHT
  };

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic [6:0] row;
    logic [6:0] col;
  } term_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       mode_we = 1'b0;
  logic       mode_val = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [6:0] char_in = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] out_char;
  logic       last;
  logic [6:0] cursor_row;
  logic [6:0] cursor_col;

  // expected terminal stream and pending console writes
  term_out_t  expected_stream[$];
  logic [6:0] pending_chars[$];
  term_out_t  want;

  // tracked terminal state
  bit          xlate_mode = 1'b0;
  bit          special_pending = 1'b0;
  int unsigned addr_phase = 0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  int send_idle_pct = 6;
  int recv_idle_pct = 54;
  int items_sent = 0;
  int xlate_items = 0;
  int results_seen = 0;
  int fail_count = 0;

  terminal_control_code_translator_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .translate_mode_we_i(mode_we),
    .translate_mode_i   (mode_val),
    .push               (push),
    .full               (full),
    .char_in_i          (char_in),
    .empty              (empty),
    .pop                (pop),
    .out_char_o         (out_char),
    .last_o             (last),
    .cursor_row_o       (cursor_row),
    .cursor_col_o       (cursor_col)
  );

  always #10 clk_i = ~clk_i;

  function automatic void row_up();
    if (row_pos <= 1) row_pos = SCREEN_ROWS;
    else row_pos--;
  endfunction

  function automatic void row_down();
    row_pos++;
    if (row_pos > SCREEN_ROWS) row_pos = 1;
  endfunction

  function automatic void translate_char(input logic [6:0] c);
    logic [6:0] seq[$];
    string      s;
    term_out_t  r;
    s = "";
    if (!xlate_mode) begin
      seq.push_back(c);
    end else if (special_pending) begin
      special_pending = 1'b0;
    end else if (addr_phase == 1) begin
      col_pos = c;
      addr_phase = 2;
    end else if (addr_phase == 2) begin
      row_pos = c;
      addr_phase = 0;
      s = $sformatf("\033[%0d;%0dH", row_pos + 1, col_pos + 1);
    end else begin
      case (c)
        C_ETX, C_EOT, C_ENQ: ;
        C_HOME: begin
          s = "\033[1;1H";
          row_pos = 0;
          col_pos = 0;
        end
        C_NL: begin
          s = "\015\012";
          col_pos = 1;
          row_down();
        end
        C_EL: s = "\033[K";
        C_CLR: begin
          s = "\033[1;1H\033[2J";
          row_pos = 0;
          col_pos = 0;
        end
        C_CR: begin
          s = "\015";
          col_pos = 1;
        end
        C_BLINK_ON:  s = "\033[5m";
        C_BLINK_OFF: s = "\033[25m";
        C_ADDR:      addr_phase = 1;
        C_ULINE_ON:  s = "\033[4m";
        C_ULINE_OFF: s = "\033[24m";
        C_UP: begin
          s = "\033[A";
          row_up();
        end
        C_RIGHT: begin
          s = "\033[C";
          col_pos++;
          if (col_pos > SCREEN_COLS) begin
            col_pos = 1;
            row_down();
          end
        end
        C_LEFT: begin
          s = "\033[D";
          if (col_pos <= 1) begin
            col_pos = SCREEN_COLS;
            row_up();
          end else begin
            col_pos--;
          end
        end
        C_DOWN: begin
          s = "\033[B";
          row_down();
        end
        C_NORMAL:  s = "\033[22m";
        C_BOLD:    s = "\033[1m";
        C_SPECIAL: special_pending = 1'b1;
        default: begin
          seq.push_back(c);
          col_pos++;
          if (col_pos > SCREEN_COLS) begin
            col_pos = 1;
            row_pos++;
            if (row_pos > SCREEN_ROWS) row_pos = SCREEN_ROWS;
          end
        end
      endcase
    end
    for (int i = 0; i < s.len(); i++) seq.push_back(7'(s[i]));
    row_pos &= 32'h7f;
    col_pos &= 32'h7f;
    while (seq.size() > 10) void'(seq.pop_back());
    foreach (seq[i]) begin
      r.ch   = seq[i];
      r.last = (i == seq.size() - 1);
      r.row  = row_pos[6:0];
      r.col  = col_pos[6:0];
      expected_stream.push_back(r);
    end
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        items_sent++;
        if (xlate_mode) xlate_items++;
        translate_char(char_in);
      end
      if (!push || !full) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          char_in <= pending_chars.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_stream.size() == 0) begin
          $error("unexpected result: out_char %0d", out_char);
          fail_count++;
        end else begin
          want = expected_stream.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %0d, got %0d", want.ch, out_char);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            fail_count++;
          end
          if (cursor_row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
            fail_count++;
          end
          if (cursor_col !== want.col) begin
            $error("cursor_col: expected %0d, got %0d", want.col, cursor_col);
            fail_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_idle();
    while (pending_chars.size() != 0 || push || expected_stream.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input bit v);
    wait_idle();
    @(posedge clk_i);
    mode_we    <= 1'b1;
    mode_val   <= v;
    xlate_mode = v;
    @(posedge clk_i);
    mode_we <= 1'b0;
  endtask

  // random console text: mostly well-formed sequences, some noise
  task automatic queue_random_text(input int n);
    int k;
    int r;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 10) begin
        pending_chars.push_back(C_ADDR);
        if ($urandom_range(3) == 0) begin
          pending_chars.push_back(7'($urandom_range(127)));
          pending_chars.push_back(7'($urandom_range(127)));
        end else begin
          pending_chars.push_back(7'($urandom_range(SCREEN_COLS - 1)));
          pending_chars.push_back(7'($urandom_range(SCREEN_ROWS - 1)));
        end
        k += 3;
      end else if (r < 14) begin
        // near the bottom right corner, then text to force wraps
        pending_chars.push_back(C_ADDR);
        pending_chars.push_back(7'($urandom_range(SCREEN_COLS - 3, SCREEN_COLS)));
        pending_chars.push_back(7'($urandom_range(SCREEN_ROWS - 2, SCREEN_ROWS + 1)));
        repeat (4) pending_chars.push_back(7'($urandom_range(C_SPACE, C_TILDE)));
        k += 7;
      end else if (r < 22) begin
        pending_chars.push_back(C_SPECIAL);
        pending_chars.push_back(7'($urandom_range(127)));
        k += 2;
      end else if (r < 55) begin
        pending_chars.push_back(CTRL_CODES[$urandom_range(N_CTRL - 1)]);
        k++;
      end else if (r < 65) begin
        pending_chars.push_back(7'($urandom_range(127)));
        k++;
      end else begin
        pending_chars.push_back(7'($urandom_range(C_SPACE, C_TILDE)));
        k++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_chars.push_back(7'd0);
    pending_chars.push_back(C_DEL);
    set_mode(1'b0);
    set_mode(1'b1);
    foreach (TRANSLATE_DIRECTED[i]) pending_chars.push_back(TRANSLATE_DIRECTED[i]);

    // mode switch in the middle of a cursor address and of a special
    pending_chars.push_back(C_ADDR);
    pending_chars.push_back(7'd5);
    set_mode(1'b0);
    pending_chars.push_back(7'h71);
    set_mode(1'b1);
    pending_chars.push_back(7'd7);
    pending_chars.push_back(C_SPECIAL);
    set_mode(1'b0);
    pending_chars.push_back(7'h78);
    set_mode(1'b1);
    pending_chars.push_back(7'h79);

    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 6 : 0;
      queue_random_text(40);
      set_mode(1'b0);
      queue_random_text(15);
      set_mode(1'b1);
      queue_random_text(55);
    end
    wait_idle();

    $display("%0d items sent (%0d translated), %0d output characters checked",
             items_sent, xlate_items, results_seen);
    $display("covered pass-through, every control code, addressing and wraps");
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
